// ===== src/sumd_frame_receiver_assert.svh =====
// Assertion macros for the checker file.
`ifndef SUMD_FRAME_RECEIVER_ASSERT_SVH
`define SUMD_FRAME_RECEIVER_ASSERT_SVH

// Antecedent in this cycle, consequent in the same cycle.
`define SFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define SFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sfr_pkg.sv =====
package sfr_pkg;

	localparam logic [7:0]  SYNC_BYTE         = 8'hA8;
	localparam logic [7:0]  STATUS_OK         = 8'h01;
	localparam logic [7:0]  STATUS_FAILSAFE   = 8'h81;
	localparam logic [7:0]  FIRST_CHANNEL_POS = 8'd3;
	localparam logic [15:0] GAP_TIMEOUT_RESET = 16'd4000;

	// register index, taken from paddr[2]
	localparam logic        REG_GAP_TIMEOUT   = 1'b0;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_DIFF = 7'b0000010,
		S_GAP  = 7'b0000100,
		S_END  = 7'b0001000,
		S_RD   = 7'b0010000,
		S_LOAD = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	// shared subtractor result
	typedef struct packed {
		logic [31:0] diff;
		logic        borrow;
		logic        zero;
	} alu_res_t;

endpackage

// ===== src/sumd_frame_receiver.sv =====
// Channel   | Direction | Payload
// ----------+-----------+--------------------------------------------------------
// s_*       | in        | tdata: rx_byte[7:0], time_us[39:8]
// m_*       | out       | tdata: channel_index[3:0], channel_value[16:4], zero pad
//           |           | tuser: failsafe; tlast: last channel of the frame
// APB       | cfg       | 0x0 gap_timeout_us[15:0]
//
// Each byte goes through the transfer, then gap subtract, gap compare and
// frame-end compare, the last three through one shared 32-bit subtractor; a
// byte with bad sync is dropped after the gap compare. On a completed frame
// with status OK or failsafe, each channel goes through read setup and
// registered store read, then output load, and is held while m_tready is low.
// s_tready is low while a byte or a frame's channels are in work.
// Reset clears frame position, count, status, previous time and the output valid;
// the channel store is not cleared, as every channel read is written earlier.
module sumd_frame_receiver
	import sfr_pkg::*;
#(
	parameter int MAX_CHANNELS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // rx_byte[7:0], time_us[39:8]
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // channel_index[3:0], channel_value[16:4], pad
	output logic        m_tuser,   // failsafe
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int STORE_SIZE = 2 * MAX_CHANNELS;
	localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
	localparam int CW         = $clog2(MAX_CHANNELS + 1);

	state_t state_q;

	// configuration
	logic [15:0] timeout_q;

	// frame state
	logic [7:0]  pos_q;
	logic [7:0]  count_q;
	logic [7:0]  status_q;
	logic [31:0] prev_q;

	// latched input and intermediate results
	logic [7:0]  byte_q;
	logic [31:0] time_q;
	logic [31:0] diff_q;

	// emission
	logic [CW-1:0] k_q;
	logic [CW-1:0] n_q;
	logic          fs_q;
	logic          last_q;
	logic [7:0]    hi_q;
	logic [7:0]    lo_q;

	logic [7:0] store_q [STORE_SIZE];

	// shared subtractor
	logic [31:0] alu_a;
	logic [31:0] alu_b;
	logic [32:0] alu_full;
	alu_res_t    alu;

	logic [7:0]    pos_eff;
	logic          gap;
	logic [9:0]    end_pos;
	logic [CW-1:0] n_w;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] rd_addr_hi;
	logic [AW-1:0] rd_addr_lo;
	logic [8:0]    pos_ext;
	logic          cfg_wr;

	assign s_tready = (state_q == S_IDLE);
	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite & pready;

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_GAP_TIMEOUT) begin
			prdata = {16'd0, timeout_q};
		end
	end

	// operand select: gap difference, gap compare, frame end, last channel
	always_comb begin
		alu_a = 32'd0;
		alu_b = 32'd0;
		unique case (state_q)
			S_DIFF: begin
				alu_a = time_q;
				alu_b = prev_q;
			end
			S_GAP: begin
				alu_a = {16'd0, timeout_q};
				alu_b = diff_q;
			end
			S_END: begin
				alu_a = {24'd0, pos_q};
				alu_b = {22'd0, end_pos};
			end
			S_RD: begin
				alu_a = 32'(k_q) + 32'd1;
				alu_b = 32'(n_q);
			end
			default: begin
				alu_a = 32'd0;
				alu_b = 32'd0;
			end
		endcase
	end

	assign alu_full    = {1'b0, alu_a} - {1'b0, alu_b};
	assign alu.diff    = alu_full[31:0];
	assign alu.borrow  = alu_full[32];
	assign alu.zero    = (alu_full[31:0] == 32'd0);

	// gap longer than the timeout when timeout - diff borrows
	assign gap     = alu.borrow;
	assign pos_eff = gap ? 8'd0 : pos_q;
	assign pos_ext = {1'b0, pos_eff};
	assign end_pos = 10'({count_q, 1'b0}) + 10'd5;
	assign n_w     = (count_q > 8'(MAX_CHANNELS)) ? CW'(MAX_CHANNELS) : CW'(count_q);

	assign mem_we    = (state_q == S_GAP) && (pos_eff >= FIRST_CHANNEL_POS)
		&& (pos_ext < 9'(FIRST_CHANNEL_POS) + 9'(STORE_SIZE));
	assign mem_waddr  = AW'(pos_eff - FIRST_CHANNEL_POS);
	assign rd_addr_hi = AW'({k_q, 1'b0});
	assign rd_addr_lo = AW'({k_q, 1'b1});

	// channel byte store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= byte_q;
		end
		hi_q <= store_q[rd_addr_hi];
		lo_q <= store_q[rd_addr_lo];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= GAP_TIMEOUT_RESET;
		end else if (cfg_wr && paddr[2] == REG_GAP_TIMEOUT) begin
			timeout_q <= pwdata[15:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_q <= s_tdata[7:0];
			time_q <= s_tdata[39:8];
		end
		if (state_q == S_DIFF) begin
			diff_q <= alu.diff;
		end
		if (state_q == S_RD) begin
			last_q <= alu.zero;
		end
		if (state_q == S_LOAD) begin
			m_tdata <= {7'd0, hi_q, lo_q[7:3], 4'(k_q)};
			m_tuser <= fs_q;
			m_tlast <= last_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pos_q    <= 8'd0;
			count_q  <= 8'd0;
			status_q <= 8'd0;
			prev_q   <= 32'd0;
			k_q      <= '0;
			n_q      <= '0;
			fs_q     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					prev_q  <= time_q;
					state_q <= S_GAP;
				end
				S_GAP: begin
					if (pos_eff == 8'd0 && byte_q != SYNC_BYTE) begin
						// bad sync: byte dropped
						pos_q   <= 8'd0;
						state_q <= S_IDLE;
					end else begin
						if (pos_eff == 8'd1) begin
							status_q <= byte_q;
						end
						if (pos_eff == 8'd2) begin
							count_q <= byte_q;
						end
						pos_q   <= pos_eff + 8'd1;
						state_q <= S_END;
					end
				end
				S_END: begin
					state_q <= S_IDLE;
					if (alu.zero) begin
						pos_q <= 8'd0;
						n_q   <= n_w;
						k_q   <= '0;
						fs_q  <= (status_q == STATUS_FAILSAFE);
						if ((status_q == STATUS_OK || status_q == STATUS_FAILSAFE)
							&& n_w != '0) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					m_tvalid <= 1'b1;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tlast) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + CW'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/sfr_chk.sv =====
`include "sumd_frame_receiver_assert.svh"

module sfr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// stalled output holds
	`SFR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output changed while stalled")

	// no byte taken while a channel waits
	`SFR_ASSERT_NOW(a_no_overlap, clk, arst_n, s_tready, !m_tvalid, "ready while output pending")

	// s_tready drops after each byte transfer while the byte is worked on
	`SFR_ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_tvalid && s_tready, !s_tready, "ready right after a byte transfer")

	// frame emission continues until the last channel
	`SFR_ASSERT_NEXT(a_busy_mid_frame, clk, arst_n, m_tvalid && m_tready && !m_tlast, !s_tready && !m_tvalid, "frame ended before last channel")

endmodule

bind sumd_frame_receiver sfr_chk u_sfr_chk (.*);
